@@ rtl/mrtd_pkg.sv @@
// ----------------------------------------------------------------------------
// MMIO region table decoder package
// Shared types and codes for the region cells and the decoder core.
// ----------------------------------------------------------------------------
package mrtd_pkg;

  localparam int AddrW    = 64;
  localparam int HandlerW = 8;
  localparam int SlotW    = 4;
  localparam int InDataW  = 144;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_READ     = 2'd1,
    OP_WRITE    = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_SUCCESS     = 3'd0,
    ST_OVERLAP     = 3'd1,
    ST_NOT_HANDLED = 3'd2,
    ST_DENIED      = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  // One stored region. The end address is exclusive.
  typedef struct packed {
    logic [AddrW-1:0]    base;
    logic [AddrW-1:0]    lim;
    logic [HandlerW-1:0] handler;
    logic                rd_ok;
    logic                wr_ok;
  } region_t;

  // Control from the core to one cell.
  typedef struct packed {
    logic capture;  // register the compare flags for a new item
    logic cmp_le;   // access lookup: base <= key, otherwise base < key
    logic shift;    // take the left neighbour's region
    logic load;     // take the new region
  } cell_ctrl_t;

  // Compare results registered in one cell.
  typedef struct packed {
    logic below;            // base below (or at, for accesses) the key
    logic key_lt_end;       // key below the stored end
    logic base_lt_new_end;  // stored base below the new region's end
  } cell_flags_t;

endpackage

@@ rtl/mmio_region_table_decoder_core.sv @@
// tvalid rises once the select-and-update step has written the result
// register; that step waits while an earlier result is stalled at the output.
// Each item takes a compare step in the region cells and a select-and-update
// step that also shifts the table; a new item is taken only after the last one
// is resolved. A waiting result does not block the next item's compare step.
// Reset (rst_ni low, asynchronous) empties the table and clears all handshake
// state; region contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// MMIO region table decoder core
// Sorted region table built as a row of cells, with insert and address lookup.
// ----------------------------------------------------------------------------
module mmio_region_table_decoder_core
  import mrtd_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata from bit 0: opcode[1:0], address[65:2], region_end[129:66],
  // handler_id[137:130], can_read[138], can_write[139], zero fill [143:140]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata from bit 0: status[2:0], matched_handler[10:3], slot[14:11],
  // zero fill [15]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Index width for one cell, and count width that can also hold the depth.
  localparam int IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CntW = $clog2(MAX_REGIONS + 1);

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  opcode_e             op_q;
  region_t             new_q;
  logic                out_valid_q;
  logic [2:0]          out_status_q;
  logic [HandlerW-1:0] out_handler_q;
  logic [SlotW-1:0]    out_slot_q;

  // Input item fields.
  logic [1:0]       in_opcode;
  logic [AddrW-1:0] in_address;
  logic [AddrW-1:0] in_end;
  region_t          in_region;

  assign in_opcode         = s_axis_tdata_i[1:0];
  assign in_address        = s_axis_tdata_i[65:2];
  assign in_end            = s_axis_tdata_i[129:66];
  assign in_region.base    = in_address;
  assign in_region.lim     = in_end;
  assign in_region.handler = s_axis_tdata_i[137:130];
  assign in_region.rd_ok   = s_axis_tdata_i[138];
  assign in_region.wr_ok   = s_axis_tdata_i[139];

  logic in_accept;
  logic resolve_go;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  // The result register must be free before a result is written and the
  // table is changed, so a stalled result holds the table as it is.
  assign resolve_go      = (state_q == S_RESOLVE) && (!out_valid_q || m_axis_tready_i);

  // ---------------------------------------------------------------------------
  // Row of cells. Cell i holds the region at sorted position i; on an insert,
  // every cell right of the insert point takes its left neighbour's region.
  // ---------------------------------------------------------------------------
  cell_ctrl_t  ctrl   [MAX_REGIONS];
  region_t     region [MAX_REGIONS];
  cell_flags_t flags  [MAX_REGIONS];

  logic            do_insert;
  logic [CntW-1:0] ins_pos;

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    region_t left;

    if (g == 0) begin : g_first
      assign left = new_q;
    end else begin : g_rest
      assign left = region[g-1];
    end

    assign ctrl[g].capture = in_accept;
    assign ctrl[g].cmp_le  = (in_opcode != OP_REGISTER);
    assign ctrl[g].load    = do_insert && (CntW'(g) == ins_pos);
    assign ctrl[g].shift   = do_insert && (CntW'(g) > ins_pos);

    mrtd_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[g]),
      .key_i     (in_address),
      .new_end_i (in_end),
      .left_i    (left),
      .new_i     (new_q),
      .region_o  (region[g]),
      .flags_o   (flags[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Selection. The table is sorted, so the valid cells whose base lies below
  // the key form a prefix. The last of them is the candidate region for an
  // access and the left neighbour of an insert; the first cell past it is the
  // right neighbour of an insert.
  // ---------------------------------------------------------------------------
  logic [MAX_REGIONS-1:0] hit;
  logic [MAX_REGIONS-1:0] last_oh;
  logic [MAX_REGIONS-1:0] next_oh;

  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      hit[i] = flags[i].below && (CntW'(i) < count_q);
    end
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (i == MAX_REGIONS - 1) begin
        last_oh[i] = hit[i];
      end else begin
        last_oh[i] = hit[i] && !hit[i+1];
      end
      if (i == 0) begin
        next_oh[i] = !hit[i] && (CntW'(i) < count_q);
      end else begin
        next_oh[i] = !hit[i] && hit[i-1] && (CntW'(i) < count_q);
      end
    end
  end

  logic                any_hit;
  logic [IdxW-1:0]     last_idx;
  logic                last_key_lt_end;
  logic                last_rd_ok;
  logic                last_wr_ok;
  logic [HandlerW-1:0] last_handler;
  logic                next_base_lt_end;

  always_comb begin
    last_idx         = '0;
    last_key_lt_end  = 1'b0;
    last_rd_ok       = 1'b0;
    last_wr_ok       = 1'b0;
    last_handler     = '0;
    next_base_lt_end = 1'b0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      last_idx         |= last_oh[i] ? IdxW'(i) : '0;
      last_key_lt_end  |= last_oh[i] && flags[i].key_lt_end;
      last_rd_ok       |= last_oh[i] && region[i].rd_ok;
      last_wr_ok       |= last_oh[i] && region[i].wr_ok;
      last_handler     |= last_oh[i] ? region[i].handler : '0;
      next_base_lt_end |= next_oh[i] && flags[i].base_lt_new_end;
    end
  end

  assign any_hit = |hit;
  assign ins_pos = any_hit ? (CntW'(last_idx) + CntW'(1)) : '0;

  // ---------------------------------------------------------------------------
  // Result decision. A full table is refused before the overlap test; an
  // empty or inverted region goes through the neighbour tests like any other.
  // ---------------------------------------------------------------------------
  logic                table_full;
  logic                overlap;
  logic [2:0]          res_status;
  logic [HandlerW-1:0] res_handler;
  logic [SlotW-1:0]    res_slot;
  logic                perm_ok;

  assign table_full = (count_q == CntW'(MAX_REGIONS));
  // Left neighbour ends past the new base, or right neighbour starts before
  // the new end. Touching ends pass.
  assign overlap    = (any_hit && last_key_lt_end) || next_base_lt_end;
  assign perm_ok    = (op_q == OP_WRITE) ? last_wr_ok : last_rd_ok;

  always_comb begin
    res_status  = ST_NOT_HANDLED;
    res_handler = '0;
    res_slot    = '0;
    do_insert   = 1'b0;
    case (op_q)
      OP_REGISTER: begin
        if (table_full) begin
          res_status = ST_FULL;
        end else if (overlap) begin
          res_status = ST_OVERLAP;
        end else begin
          res_status = ST_SUCCESS;
          res_slot   = SlotW'(ins_pos);
          do_insert  = resolve_go;
        end
      end
      OP_READ, OP_WRITE: begin
        if (any_hit && last_key_lt_end) begin
          res_slot = SlotW'(last_idx);
          if (perm_ok) begin
            res_status  = ST_SUCCESS;
            res_handler = last_handler;
          end else begin
            res_status  = ST_DENIED;
          end
        end
      end
      default: begin
        res_status = ST_NOT_HANDLED;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state, region count and the result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= '0;
      out_handler_q <= '0;
      out_slot_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (resolve_go) begin
            state_q <= S_IDLE;
            if (do_insert) begin
              count_q <= count_q + CntW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // A new result replaces the one taken in the same cycle.
      if (resolve_go) begin
        out_valid_q   <= 1'b1;
        out_status_q  <= res_status;
        out_handler_q <= res_handler;
        out_slot_q    <= res_slot;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= opcode_e'(in_opcode);
      new_q <= in_region;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_slot_q, out_handler_q, out_status_q};

endmodule

@@ rtl/mrtd_cell.sv @@
// ----------------------------------------------------------------------------
// MMIO region table cell
// Holds one sorted region, compares it against the incoming key and shifts
// its region to the right-hand neighbour when a new region is inserted.
// ----------------------------------------------------------------------------
module mrtd_cell
  import mrtd_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [AddrW-1:0]  key_i,
  input  logic [AddrW-1:0]  new_end_i,
  input  region_t           left_i,
  input  region_t           new_i,
  output region_t           region_o,
  output cell_flags_t       flags_o
);

  region_t     region_q, region_d;
  cell_flags_t flags_q, flags_d;

  always_comb begin
    region_d = region_q;
    if (ctrl_i.load) begin
      region_d = new_i;
    end else if (ctrl_i.shift) begin
      region_d = left_i;
    end
  end

  always_comb begin
    flags_d                 = flags_q;
    if (ctrl_i.capture) begin
      flags_d.below           = ctrl_i.cmp_le ? (region_q.base <= key_i)
                                              : (region_q.base < key_i);
      flags_d.key_lt_end      = key_i < region_q.lim;
      flags_d.base_lt_new_end = region_q.base < new_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    flags_q  <= flags_d;
  end

  assign region_o = region_q;
  assign flags_o  = flags_q;

endmodule

@@ tb/mmio_region_table_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMIO region table decoder core testbench
// Drives register, read, write and unknown items through the input stream; each
// result is checked against a directed row or a behavioural region table copy.
// ----------------------------------------------------------------------------
module mmio_region_table_decoder_core_tb;
  import mrtd_pkg::*;

  localparam int          MaxRegions = 16;
  localparam int          RandItems  = 1526;
  localparam logic [1:0]  OpUnknown  = 2'd3;

  // One input item; the last member lands in the lowest bits of tdata.
  typedef struct packed {
    logic                can_write;
    logic                can_read;
    logic [HandlerW-1:0] handler_id;
    logic [AddrW-1:0]    region_end;
    logic [AddrW-1:0]    address;
    logic [1:0]          opcode;
  } mmio_req_t;

  typedef struct {
    status_e             status;
    logic [HandlerW-1:0] handler;
    logic [SlotW-1:0]    slot;
  } decode_result_t;

  // Directed stimulus row; the result columns count only when known is set.
  typedef struct {
    logic [1:0]          opcode;
    logic [AddrW-1:0]    address;
    logic [AddrW-1:0]    region_end;
    logic [HandlerW-1:0] handler_id;
    logic                can_read;
    logic                can_write;
    bit                  known;
    status_e             status;
    logic [HandlerW-1:0] handler;
    logic [SlotW-1:0]    slot;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Behavioural copy of the sorted region table.
  region_t        region_tab [MaxRegions];
  int             region_cnt = 0;
  decode_result_t pending_results [$];
  int             fail_count = 0;
  bit             tx_burst   = 1'b0;
  bit             rx_burst   = 1'b0;
  dir_row_t       dir_rows [24];

  mmio_region_table_decoder_core #(
    .MAX_REGIONS     (MaxRegions)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Works out the result of one item and updates the region table copy.
  function automatic decode_result_t decode_region(input mmio_req_t req);
    decode_result_t res;
    int             pos;
    int             k;
    logic           allowed;
    res = '{ST_NOT_HANDLED, '0, '0};
    pos = 0;
    if (req.opcode == OP_REGISTER) begin
      if (region_cnt >= MaxRegions) begin
        res.status = ST_FULL;
      end else begin
        while (pos < region_cnt && region_tab[pos].base < req.address) pos++;
        if (pos > 0 && req.address < region_tab[pos-1].lim) begin
          res.status = ST_OVERLAP;
        end else if (pos < region_cnt && region_tab[pos].base < req.region_end) begin
          res.status = ST_OVERLAP;
        end else begin
          for (k = region_cnt; k > pos; k--) region_tab[k] = region_tab[k-1];
          region_tab[pos] = '{req.address, req.region_end, req.handler_id,
                              req.can_read, req.can_write};
          region_cnt++;
          res.status = ST_SUCCESS;
          res.slot   = pos[SlotW-1:0];
        end
      end
    end else if (req.opcode == OP_READ || req.opcode == OP_WRITE) begin
      // Only the last region whose base is at or below the address counts.
      while (pos < region_cnt && region_tab[pos].base <= req.address) pos++;
      if (pos > 0 && req.address < region_tab[pos-1].lim) begin
        allowed = (req.opcode == OP_WRITE) ? region_tab[pos-1].wr_ok
                                           : region_tab[pos-1].rd_ok;
        res.slot = SlotW'(pos - 1);
        if (allowed) begin
          res.status  = ST_SUCCESS;
          res.handler = region_tab[pos-1].handler;
        end else begin
          res.status = ST_DENIED;
        end
      end
    end
    return res;
  endfunction

  // Presents one item after a random gap and queues its expected result.
  task automatic send_item(input mmio_req_t req, input bit use_typed,
                           input decode_result_t typed_res);
    int             gap;
    decode_result_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW - $bits(mmio_req_t)){1'b0}}, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = decode_region(req);
    pending_results.push_back(use_typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, then compare against the oldest expectation.
  initial begin
    decode_result_t exp_res;
    decode_result_t got;
    int             stall;
    int             seen;
    seen = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (seen % 100 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      seen++;
      got.status  = status_e'(m_axis_tdata_o[2:0]);
      got.handler = m_axis_tdata_o[10:3];
      got.slot    = m_axis_tdata_o[14:11];
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting: %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, got.status);
          fail_count++;
        end
        if (got.handler !== exp_res.handler) begin
          $error("matched_handler: expected %0h, got %0h", exp_res.handler, got.handler);
          fail_count++;
        end
        if (got.slot !== exp_res.slot) begin
          $error("slot: expected %0d, got %0d", exp_res.slot, got.slot);
          fail_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    mmio_req_t      req;
    decode_result_t typed_res;
    int             n;
    int             pick;
    int             idx;
    logic [63:0]    span;

    // Extremes, every opcode, touching and overlapping neighbours, empty and
    // inverted regions, equal bases and the top of the address space.
    dir_rows = '{
      '{OP_READ,     64'h0, 64'h0, 8'h00, 1'b0, 1'b0, 1, ST_NOT_HANDLED, 8'h00, 4'd0},
      '{OP_WRITE,    '1,    '1,    8'hFF, 1'b1, 1'b1, 1, ST_NOT_HANDLED, 8'h00, 4'd0},
      '{OpUnknown,   '1,    '1,    8'hFF, 1'b1, 1'b1, 1, ST_NOT_HANDLED, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h1000, 64'h2000, 8'hFF, 1'b1, 1'b0, 1, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     64'h1000, 64'h0,    8'h00, 1'b0, 1'b0, 1, ST_SUCCESS, 8'hFF, 4'd0},
      '{OP_WRITE,    64'h1FFF, 64'h0,    8'h00, 1'b0, 1'b0, 1, ST_DENIED,  8'h00, 4'd0},
      '{OP_READ,     64'h2000, 64'h0,    8'h00, 1'b0, 1'b0, 1, ST_NOT_HANDLED, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h2000, 64'h3000, 8'h00, 1'b0, 1'b1, 1, ST_SUCCESS, 8'h00, 4'd1},
      '{OP_REGISTER, 64'h1800, 64'h2800, 8'h11, 1'b1, 1'b1, 1, ST_OVERLAP, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h0800, 64'h1001, 8'h22, 1'b1, 1'b1, 1, ST_OVERLAP, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h0,    64'h1000, 8'hA5, 1'b1, 1'b1, 1, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h1000, 64'h1000, 8'h33, 1'b1, 1'b1, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     64'h1000, 64'h0,    8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 8'h5A, 1'b1, 1'b1,
        0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     '1,    64'h0, 8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h8000_0000_0000_0000, '1, 8'h3C, 1'b0, 1'b1,
        0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_REGISTER, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFF0, 8'h3C, 1'b0, 1'b1,
        0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_WRITE,    64'hFFFF_FFFF_FFFF_FFEF, 64'h0, 8'h00, 1'b0, 1'b0,
        0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     64'h8000_0000_0000_0000, 64'h0, 8'h00, 1'b0, 1'b0,
        0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_WRITE,    64'h2FFF, 64'h0, 8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     64'h0,    64'h0, 8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OpUnknown,   64'h1000, 64'h0, 8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_REGISTER, '1,    '1,    8'h81, 1'b1, 1'b1, 0, ST_SUCCESS, 8'h00, 4'd0},
      '{OP_READ,     '1,    64'h0, 8'h00, 1'b0, 1'b0, 0, ST_SUCCESS, 8'h00, 4'd0}
    };

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      req       = '{dir_rows[i].can_write, dir_rows[i].can_read, dir_rows[i].handler_id,
                    dir_rows[i].region_end, dir_rows[i].address, dir_rows[i].opcode};
      typed_res = '{dir_rows[i].status, dir_rows[i].handler, dir_rows[i].slot};
      send_item(req, dir_rows[i].known, typed_res);
    end

    // Mostly accesses aimed at stored regions and their edges; registrations
    // are kept rare so that the table fills slowly over the run.
    for (n = 0; n < RandItems; n++) begin
      if (n % 100 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      req.handler_id = HandlerW'($urandom);
      req.can_read   = 1'($urandom);
      req.can_write  = 1'($urandom);
      req.address    = {$urandom, $urandom};
      req.region_end = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        req.opcode = OP_REGISTER;
        case ($urandom_range(0, 3))
          0, 1: begin
            req.address    = 64'($urandom_range(0, 32'hF_FFFF));
            req.region_end = req.address + 64'($urandom_range(1, 32'h3000));
          end
          2: begin
            // Near the top of the address space; the end may wrap round.
            req.address    = 64'hFFFF_FFFF_FFF0_0000 | 64'($urandom_range(0, 32'hF_FFFF));
            req.region_end = req.address + 64'($urandom_range(0, 32'h3000));
          end
          default: begin
            // Touching or just overlapping a stored region's end.
            if (region_cnt > 0) begin
              idx            = $urandom_range(0, region_cnt - 1);
              req.address    = region_tab[idx].lim - 64'($urandom_range(0, 1));
              req.region_end = req.address + 64'($urandom_range(0, 32'h2000));
            end
          end
        endcase
      end else if (pick < 4) begin
        req.opcode = OpUnknown;
      end else begin
        req.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        if (region_cnt > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, region_cnt - 1);
          case ($urandom_range(0, 4))
            0: req.address = region_tab[idx].base;
            1: req.address = region_tab[idx].lim - 64'd1;
            2: req.address = region_tab[idx].lim;
            3: req.address = region_tab[idx].base - 64'd1;
            default: begin
              span        = region_tab[idx].lim - region_tab[idx].base;
              req.address = region_tab[idx].base;
              if (region_tab[idx].lim > region_tab[idx].base)
                req.address += {$urandom, $urandom} % span;
            end
          endcase
        end else if ($urandom_range(0, 1)) begin
          req.address = 64'($urandom_range(0, 32'hF_FFFF));
        end
      end
      typed_res = '{ST_NOT_HANDLED, '0, '0};
      send_item(req, 1'b0, typed_res);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    // Any stray result item would show up before the end of the run.
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("mmio_region_table_decoder_core_tb: PASS");
    end else begin
      $display("mmio_region_table_decoder_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("mmio_region_table_decoder_core_tb: FAIL");
    $finish;
  end

endmodule
